>>> src/indirect_buffer_pool_submitter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the command buffer pool submitter
// Clocked implication checks used by the submitter top level.
// ----------------------------------------------------------------------------
`ifndef INDIRECT_BUFFER_POOL_SUBMITTER_ASSERT_SVH
`define INDIRECT_BUFFER_POOL_SUBMITTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IBPS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/ibps_pkg.sv
// ----------------------------------------------------------------------------
// Command buffer pool package
// Sizes, codes, sequencer states and shared structures of the pool submitter.
// ----------------------------------------------------------------------------
package ibps_pkg;

    // Pool geometry.
    localparam int NUM_BUFFERS           = 16;
    localparam int BUFFER_CAPACITY_WORDS = 4096;
    localparam int IDX_W                 = $clog2(NUM_BUFFERS);
    localparam int STEP_W                = $clog2(NUM_BUFFERS + 1);

    // Byte distance between two neighbouring buffers.
    localparam logic [31:0] BUF_STRIDE = 32'(BUFFER_CAPACITY_WORDS * 4);

    // A link holds a buffer index; the top bit marks the empty link.
    typedef logic [IDX_W:0] t_link;
    localparam t_link LINK_NONE = {1'b1, {IDX_W{1'b0}}};

    // Operation codes.
    localparam logic [2:0] FUNC_ALLOC      = 3'd0;
    localparam logic [2:0] FUNC_FREE       = 3'd1;
    localparam logic [2:0] FUNC_SUBMIT     = 3'd2;
    localparam logic [2:0] FUNC_RETIRE     = 3'd3;
    localparam logic [2:0] FUNC_INVALIDATE = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_AREA_BASE  = 2'd0;
    localparam logic [1:0] CFG_BUF_HEADER = 2'd1;
    localparam logic [1:0] CFG_TAG_HEADER = 2'd2;

    // Positions in the ring word sequence of a submit.
    localparam logic [2:0] WP_STATE_HDR  = 3'd0;
    localparam logic [2:0] WP_STATE_ADDR = 3'd1;
    localparam logic [2:0] WP_STATE_LEN  = 3'd2;
    localparam logic [2:0] WP_BUF_HDR    = 3'd3;
    localparam logic [2:0] WP_BUF_ADDR   = 3'd4;
    localparam logic [2:0] WP_BUF_LEN    = 3'd5;
    localparam logic [2:0] WP_TAG_HDR    = 3'd6;
    localparam logic [2:0] WP_TAG_VAL    = 3'd7;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_TAG,
        S_LINK,
        S_EMIT,
        S_RETIRE
    } t_state;

    // Request to the shared add/subtract unit.
    typedef struct packed {
        logic        sub;
        logic [31:0] a;
        logic [31:0] b;
    } t_alu_req;

    // Write requests to the link and tag tables.
    typedef struct packed {
        logic             link_we;
        logic [IDX_W-1:0] link_addr;
        t_link            link_data;
        logic             tag_we;
        logic [IDX_W-1:0] tag_addr;
        logic [31:0]      tag_data;
    } t_tbl_wr;

    // Reset value of one link: a chain through all buffers.
    function automatic t_link link_reset_value(input int idx);
        t_link v;
        v = LINK_NONE;
        if (idx + 1 < NUM_BUFFERS) begin
            v = t_link'(idx + 1);
        end
        return v;
    endfunction

    // Byte offset of a buffer from the start of the buffer area.
    function automatic logic [31:0] buf_offset(input logic [3:0] idx);
        return 32'({28'd0, idx}) * BUF_STRIDE;
    endfunction

endpackage

>>> src/ibps_alu.sv
// ----------------------------------------------------------------------------
// Shared add/subtract unit
// One 32-bit adder used for tag increments, bus addresses and tag compares.
// ----------------------------------------------------------------------------
module ibps_alu (
    input  ibps_pkg::t_alu_req i_req,
    output logic [31:0]        o_y
);
    import ibps_pkg::*;

    // Subtraction also gives the wrap-safe tag distance in its sign bit.
    always_comb begin
        if (i_req.sub) begin
            o_y = i_req.a - i_req.b;
        end else begin
            o_y = i_req.a + i_req.b;
        end
    end

endmodule

>>> src/ibps_tables.sv
// ----------------------------------------------------------------------------
// Link and tag tables
// Per-buffer next links and fence tags, one shared read address.
// ----------------------------------------------------------------------------
module ibps_tables (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ibps_pkg::t_tbl_wr             i_wr,
    input  logic [ibps_pkg::IDX_W-1:0]    i_rd_addr,
    output ibps_pkg::t_link               o_link_rd,
    output logic [31:0]                   o_tag_rd
);
    import ibps_pkg::*;

    t_link       r_link [NUM_BUFFERS];
    logic [31:0] r_tag  [NUM_BUFFERS];

    // Link table: reset builds the free chain through every buffer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_BUFFERS; i++) begin
                r_link[i] <= link_reset_value(i);
            end
        end else if (i_wr.link_we) begin
            r_link[i_wr.link_addr] <= i_wr.link_data;
        end
    end

    // Tag table: holds nothing meaningful until a submit writes it.
    always_ff @(posedge i_clk) begin
        if (i_wr.tag_we) begin
            r_tag[i_wr.tag_addr] <= i_wr.tag_data;
        end
    end

    // Read port.
    assign o_link_rd = r_link[i_rd_addr];
    assign o_tag_rd  = r_tag[i_rd_addr];

endmodule

>>> src/indirect_buffer_pool_submitter.sv
// ----------------------------------------------------------------------------
// Command buffer pool submitter
// Free list, fence-tagged list of submitted buffers and ring word generation.
// ----------------------------------------------------------------------------
//  Channel   Ports                                         Transfer when
//  -------   --------------------------------------------  ---------------------
//  command   i_start, o_busy, i_func .. i_done_tag          i_start && !o_busy
//  result    o_strobe, o_command_word .. o_assigned_tag     o_strobe (no stall)
//  config    i_cfg_we, i_cfg_index, i_cfg_data              i_cfg_we
//
//  Alloc, free, invalidate and unused codes are busy for one cycle, and the
//  result is driven in the next, when a new command may already be given.
//  Submit is busy in the execute, tag and link set-up states, then emits one
//  ring word per cycle, 8 or 5 as a state packet is sent or not, as the one
//  shared adder forms tag and addresses; retire frees at most NUM_BUFFERS, one a cycle.
//  Reset is synchronous and rebuilds the link chain at once; no receiver stall.
// ----------------------------------------------------------------------------
module indirect_buffer_pool_submitter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Command channel
    input  logic        i_start,
    output logic        o_busy,
    input  logic [2:0]  i_func,
    input  logic [3:0]  i_buffer_index,
    input  logic [12:0] i_buffer_words,
    input  logic [3:0]  i_state_index,
    input  logic [12:0] i_state_words,
    input  logic [31:0] i_done_tag,
    // Result channel
    output logic        o_strobe,
    output logic [31:0] o_command_word,
    output logic        o_last,
    output logic [3:0]  o_granted_index,
    output logic        o_status,
    output logic [4:0]  o_freed_count,
    output logic [31:0] o_assigned_tag,
    // Configuration port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import ibps_pkg::*;

    `include "indirect_buffer_pool_submitter_assert.svh"

    // Sequencer and list state
    t_state              r_state, n_state;
    t_link               r_free_head, n_free_head;
    t_link               r_oldest, n_oldest;
    t_link               r_newest, n_newest;
    logic                r_active_vld, n_active_vld;
    logic [3:0]          r_active_idx, n_active_idx;
    logic [31:0]         r_tag_counter, n_tag_counter;
    logic [2:0]          r_k, n_k;
    logic [STEP_W-1:0]   r_steps, n_steps;
    logic [4:0]          r_freed, n_freed;
    logic [13:0]         r_bw_pad, n_bw_pad;

    // Configuration registers
    logic [31:0]         r_area_base;
    logic [31:0]         r_buf_header;
    logic [31:0]         r_tag_header;

    // Latched command
    logic [2:0]          r_func;
    logic [3:0]          r_bidx;
    logic [12:0]         r_bwords;
    logic [3:0]          r_sidx;
    logic [12:0]         r_swords;
    logic [31:0]         r_done;

    // Result registers
    logic                r_strobe, n_strobe;
    logic [31:0]         r_word, n_word;
    logic                r_last, n_last;
    logic [3:0]          r_granted, n_granted;
    logic                r_status, n_status;
    logic [4:0]          r_freed_out, n_freed_out;
    logic [31:0]         r_tag_out, n_tag_out;

    // Shared unit and table interface
    t_alu_req            alu_req;
    logic [31:0]         alu_y;
    t_tbl_wr             tbl_wr;
    logic [IDX_W-1:0]    tbl_rd_addr;
    t_link               link_rd;
    logic [31:0]         tag_rd;

    logic                accept;
    logic                bidx_ok;
    logic                need_state;
    logic                retire_stop;

    assign accept  = i_start && (r_state == S_IDLE);
    assign o_busy  = (r_state != S_IDLE);
    assign bidx_ok = int'(r_bidx) < NUM_BUFFERS;

    // A state packet is sent when a state buffer is asked for and not active.
    assign need_state = (r_swords != 13'd0) &&
                        !(r_active_vld && (r_active_idx == r_sidx));

    // The walk stops at the list end, the step bound or an unreached tag.
    assign retire_stop = r_oldest[IDX_W] || (r_steps == STEP_W'(NUM_BUFFERS)) ||
                         alu_y[31];

    ibps_alu u_alu (
        .i_req (alu_req),
        .o_y   (alu_y)
    );

    ibps_tables u_tables (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (tbl_wr),
        .i_rd_addr (tbl_rd_addr),
        .o_link_rd (link_rd),
        .o_tag_rd  (tag_rd)
    );

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_func == FUNC_SUBMIT && bidx_ok) begin
                    n_state = S_TAG;
                end else if (r_func == FUNC_RETIRE) begin
                    n_state = S_RETIRE;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_TAG: begin
                n_state = S_LINK;
            end
            S_LINK: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (r_k == WP_TAG_VAL) begin
                    n_state = S_IDLE;
                end
            end
            S_RETIRE: begin
                if (retire_stop) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath control: list updates, shared unit operands and results.
    always_comb begin
        n_free_head   = r_free_head;
        n_oldest      = r_oldest;
        n_newest      = r_newest;
        n_active_vld  = r_active_vld;
        n_active_idx  = r_active_idx;
        n_tag_counter = r_tag_counter;
        n_k           = r_k;
        n_steps       = r_steps;
        n_freed       = r_freed;
        n_bw_pad      = r_bw_pad;

        n_strobe      = 1'b0;
        n_word        = '0;
        n_last        = 1'b0;
        n_granted     = '0;
        n_status      = 1'b0;
        n_freed_out   = '0;
        n_tag_out     = '0;

        alu_req.sub   = 1'b0;
        alu_req.a     = r_tag_counter;
        alu_req.b     = 32'd1;

        tbl_wr        = '0;
        tbl_rd_addr   = r_free_head[IDX_W-1:0];

        case (r_state)
            S_EXEC: begin
                case (r_func)
                    FUNC_ALLOC: begin
                        n_strobe = 1'b1;
                        n_last   = 1'b1;
                        if (r_free_head[IDX_W]) begin
                            n_status = 1'b1;
                        end else begin
                            n_granted   = 4'(r_free_head[IDX_W-1:0]);
                            n_free_head = link_rd;
                        end
                    end
                    FUNC_FREE: begin
                        n_strobe = 1'b1;
                        n_last   = 1'b1;
                        if (bidx_ok) begin
                            tbl_wr.link_we   = 1'b1;
                            tbl_wr.link_addr = IDX_W'(r_bidx);
                            tbl_wr.link_data = r_free_head;
                            n_free_head      = t_link'(IDX_W'(r_bidx));
                        end
                    end
                    FUNC_SUBMIT: begin
                        if (bidx_ok) begin
                            n_bw_pad = {1'b0, r_bwords} + {13'd0, r_bwords[0]};
                            if (need_state) begin
                                n_active_vld = 1'b1;
                                n_active_idx = r_sidx;
                                n_k          = WP_STATE_HDR;
                            end else begin
                                n_k          = WP_BUF_HDR;
                            end
                        end else begin
                            n_strobe = 1'b1;
                            n_last   = 1'b1;
                        end
                    end
                    FUNC_RETIRE: begin
                        n_steps = '0;
                        n_freed = '0;
                    end
                    FUNC_INVALIDATE: begin
                        n_strobe = 1'b1;
                        n_last   = 1'b1;
                        if (r_active_vld && (r_active_idx == r_sidx)) begin
                            n_active_vld = 1'b0;
                        end
                    end
                    default: begin
                        n_strobe = 1'b1;
                        n_last   = 1'b1;
                    end
                endcase
            end
            S_TAG: begin
                // New fence tag, and the buffer goes to the tail of the sent list.
                n_tag_counter   = alu_y;
                tbl_wr.tag_we   = 1'b1;
                tbl_wr.tag_addr = IDX_W'(r_bidx);
                tbl_wr.tag_data = alu_y;
                if (!r_newest[IDX_W]) begin
                    tbl_wr.link_we   = 1'b1;
                    tbl_wr.link_addr = r_newest[IDX_W-1:0];
                    tbl_wr.link_data = t_link'(IDX_W'(r_bidx));
                end else begin
                    n_oldest = t_link'(IDX_W'(r_bidx));
                end
                n_newest = t_link'(IDX_W'(r_bidx));
            end
            S_LINK: begin
                // The new tail ends the sent list.
                tbl_wr.link_we   = 1'b1;
                tbl_wr.link_addr = IDX_W'(r_bidx);
                tbl_wr.link_data = LINK_NONE;
            end
            S_EMIT: begin
                // One ring word per cycle; the adder forms the bus addresses.
                alu_req.sub = 1'b0;
                alu_req.a   = r_area_base;
                alu_req.b   = buf_offset((r_k == WP_STATE_ADDR) ? r_sidx : r_bidx);
                n_strobe    = 1'b1;
                n_last      = (r_k == WP_TAG_VAL);
                n_tag_out   = r_tag_counter;
                n_k         = r_k + 3'd1;
                case (r_k)
                    WP_STATE_HDR:  n_word = r_buf_header;
                    WP_STATE_ADDR: n_word = alu_y;
                    WP_STATE_LEN:  n_word = {19'd0, r_swords};
                    WP_BUF_HDR:    n_word = r_buf_header;
                    WP_BUF_ADDR:   n_word = alu_y;
                    WP_BUF_LEN:    n_word = {18'd0, r_bw_pad};
                    WP_TAG_HDR:    n_word = r_tag_header;
                    WP_TAG_VAL:    n_word = r_tag_counter;
                    default:       n_word = '0;
                endcase
            end
            S_RETIRE: begin
                // One sent buffer per cycle, oldest first.
                tbl_rd_addr = r_oldest[IDX_W-1:0];
                alu_req.sub = 1'b1;
                alu_req.a   = r_done;
                alu_req.b   = tag_rd;
                if (retire_stop) begin
                    n_strobe    = 1'b1;
                    n_last      = 1'b1;
                    n_freed_out = r_freed;
                end else begin
                    tbl_wr.link_we   = 1'b1;
                    tbl_wr.link_addr = r_oldest[IDX_W-1:0];
                    tbl_wr.link_data = r_free_head;
                    n_free_head      = r_oldest;
                    n_oldest         = link_rd;
                    if (link_rd[IDX_W]) begin
                        n_newest = LINK_NONE;
                    end
                    if (r_freed != 5'd31) begin
                        n_freed = r_freed + 5'd1;
                    end
                    n_steps = r_steps + STEP_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_free_head   <= '0;
            r_oldest      <= LINK_NONE;
            r_newest      <= LINK_NONE;
            r_active_vld  <= 1'b0;
            r_tag_counter <= '0;
            r_strobe      <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_free_head   <= n_free_head;
            r_oldest      <= n_oldest;
            r_newest      <= n_newest;
            r_active_vld  <= n_active_vld;
            r_tag_counter <= n_tag_counter;
            r_strobe      <= n_strobe;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area_base  <= '0;
            r_buf_header <= '0;
            r_tag_header <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_AREA_BASE:  r_area_base  <= i_cfg_data;
                CFG_BUF_HEADER: r_buf_header <= i_cfg_data;
                CFG_TAG_HEADER: r_tag_header <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Payload registers: command latch, counters and result fields.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func   <= i_func;
            r_bidx   <= i_buffer_index;
            r_bwords <= i_buffer_words;
            r_sidx   <= i_state_index;
            r_swords <= i_state_words;
            r_done   <= i_done_tag;
        end
        r_active_idx <= n_active_idx;
        r_k          <= n_k;
        r_steps      <= n_steps;
        r_freed      <= n_freed;
        r_bw_pad     <= n_bw_pad;
        r_word       <= n_word;
        r_last       <= n_last;
        r_granted    <= n_granted;
        r_status     <= n_status;
        r_freed_out  <= n_freed_out;
        r_tag_out    <= n_tag_out;
    end

    assign o_strobe        = r_strobe;
    assign o_command_word  = r_word;
    assign o_last          = r_last;
    assign o_granted_index = r_granted;
    assign o_status        = r_status;
    assign o_freed_count   = r_freed_out;
    assign o_assigned_tag  = r_tag_out;

    // Checks on the sequencer and result stream.
    `IBPS_ASSERT_SAME(a_last_frees, i_clk, i_rst_n, o_strobe && o_last, !o_busy, "busy after final result")
    `IBPS_ASSERT_SAME(a_mid_busy, i_clk, i_rst_n, o_strobe && !o_last, o_busy, "idle during a submit")
    `IBPS_ASSERT_NEXT(a_take_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy && !o_strobe, "transfer not taken up")
    `IBPS_ASSERT_SAME(a_empty_alone, i_clk, i_rst_n, o_strobe && o_status, o_last && (o_freed_count == 5'd0) && (o_command_word == 32'd0), "empty flag on a wrong result")

endmodule
